// ===== rtl/rsa_me_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_me_pkg
// Shared types and constants of the modular exponentiation block: microcode
// control word, step addresses and configuration register indexes.
// ----------------------------------------------------------------------------
package rsa_me_pkg;

    localparam int EXP_WIDTH       = 32;
    localparam int EXP_CNT_WIDTH   = 5;
    localparam int CFG_INDEX_WIDTH = 8;
    localparam int CFG_DATA_WIDTH  = 32;
    localparam int BYTE_WIDTH      = 8;
    localparam int CIPHER_WIDTH    = 32;
    localparam int PC_WIDTH        = 3;

    typedef logic [PC_WIDTH-1:0]        pc_t;
    typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;

    localparam cfg_index_t REG_MODULUS      = 8'd0;
    localparam cfg_index_t REG_KEY_EXPONENT = 8'd1;

    localparam pc_t S_WAIT = 3'd0;
    localparam pc_t S_CHKM = 3'd1;
    localparam pc_t S_BASE = 3'd2;
    localparam pc_t S_SQR  = 3'd3;
    localparam pc_t S_TEST = 3'd4;
    localparam pc_t S_MULB = 3'd5;
    localparam pc_t S_DEC  = 3'd6;
    localparam pc_t S_OUT  = 3'd7;

    typedef enum logic [2:0] {
        ACT_NONE = 3'd0,
        ACT_LOAD = 3'd1,
        ACT_MUL  = 3'd2,
        ACT_DEC  = 3'd3,
        ACT_OUT  = 3'd4
    } act_t;

    typedef enum logic [1:0] {
        MSEL_BASE = 2'd0,
        MSEL_SQR  = 2'd1,
        MSEL_MULB = 2'd2
    } msel_t;

    typedef enum logic [2:0] {
        C_NO_IN    = 3'd0,
        C_MZERO    = 3'd1,
        C_MUL_WAIT = 3'd2,
        C_EBIT0    = 3'd3,
        C_CNT_NZ   = 3'd4,
        C_OUT_BUSY = 3'd5
    } cond_t;

    typedef struct packed {
        act_t  act;
        msel_t msel;
        cond_t cond;
        pc_t   target;
    } ctrl_t;

endpackage

// ===== rtl/rsa_me_ucode_rom.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_me_ucode_rom
// Microcode table: one control word per step of the square-and-multiply
// program, jump taken to target when the step condition holds.
// ----------------------------------------------------------------------------
module rsa_me_ucode_rom
    import rsa_me_pkg::*;
(
    input  pc_t   pc,
    output ctrl_t ctrl
);

    always_comb
    begin
        unique case (pc)
            S_WAIT:  ctrl = '{act: ACT_LOAD, msel: MSEL_BASE, cond: C_NO_IN,    target: S_WAIT};
            S_CHKM:  ctrl = '{act: ACT_NONE, msel: MSEL_BASE, cond: C_MZERO,    target: S_OUT};
            S_BASE:  ctrl = '{act: ACT_MUL,  msel: MSEL_BASE, cond: C_MUL_WAIT, target: S_BASE};
            S_SQR:   ctrl = '{act: ACT_MUL,  msel: MSEL_SQR,  cond: C_MUL_WAIT, target: S_SQR};
            S_TEST:  ctrl = '{act: ACT_NONE, msel: MSEL_SQR,  cond: C_EBIT0,    target: S_DEC};
            S_MULB:  ctrl = '{act: ACT_MUL,  msel: MSEL_MULB, cond: C_MUL_WAIT, target: S_MULB};
            S_DEC:   ctrl = '{act: ACT_DEC,  msel: MSEL_SQR,  cond: C_CNT_NZ,   target: S_SQR};
            S_OUT:   ctrl = '{act: ACT_OUT,  msel: MSEL_SQR,  cond: C_OUT_BUSY, target: S_OUT};
            default: ctrl = '{act: ACT_NONE, msel: MSEL_BASE, cond: C_NO_IN,    target: S_WAIT};
        endcase
    end

endmodule

// ===== rtl/rsa_me_mulmod.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_me_mulmod
// Bit-serial modular multiplier: (a * b) mod m by shift-and-add from the top
// bit of b, one bit per cycle, for a and b below m.
// ----------------------------------------------------------------------------
module rsa_me_mulmod
    import rsa_me_pkg::*;
#(
    parameter int W = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic [W-1:0] m,
    output logic         busy,
    output logic         done,
    output logic [W-1:0] result
);

    localparam int CW = $clog2(W);

    logic [W-1:0]  a_reg;
    logic [W-1:0]  b_reg;
    logic [W-1:0]  m_reg;
    logic [W-1:0]  r_reg;
    logic [W-1:0]  r_next;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [W:0]    dbl;
    logic [W:0]    dbl_red;
    logic [W:0]    sum;
    logic [W:0]    sum_red;

    always_comb
    begin
        dbl     = {1'b0, r_reg} + {1'b0, r_reg};
        dbl_red = (dbl >= {1'b0, m_reg}) ? (dbl - {1'b0, m_reg}) : dbl;
        sum     = {1'b0, dbl_red[W-1:0]} + {1'b0, a_reg};
        sum_red = (sum >= {1'b0, m_reg}) ? (sum - {1'b0, m_reg}) : sum;
        r_next  = b_reg[W-1] ? sum_red[W-1:0] : dbl_red[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
            m_reg <= m;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            r_reg <= r_next;
            b_reg <= {b_reg[W-2:0], 1'b0};
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = r_reg;

    // no new request while a product is still in flight
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (!busy_reg && !done_reg))
        else $error("mulmod started while busy");

    // a finished product is reduced below a nonzero modulus
    a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (m_reg != '0)) |-> (r_reg < m_reg))
        else $error("mulmod result not reduced");

    // the done pulse follows the last iteration
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("mulmod done without work");

endmodule

// ===== rtl/rsa_modular_exponentiation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_modular_exponentiation
// Textbook RSA on one byte per request: message_byte ^ key_exponent mod
// modulus, square-and-multiply over the 32 exponent bits, microcoded control.
// ----------------------------------------------------------------------------
// latency per request is set by the bit-serial modular multiplier and grows with
// MOD_WIDTH and with the number of set bits in key_exponent
// a zero modulus skips the multiplies and answers 0
// one request at a time; in_stall holds new bytes until the sequencer is back in its wait step
// reset: modulus and key_exponent are 1, no result pending, sequencer waits
// ----------------------------------------------------------------------------
module rsa_modular_exponentiation
    import rsa_me_pkg::*;
#(
    parameter int MOD_WIDTH = 32
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [BYTE_WIDTH-1:0]      message_byte,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [CIPHER_WIDTH-1:0]    cipher_word,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

    localparam int W = MOD_WIDTH;

    logic [CFG_DATA_WIDTH-1:0] modulus_reg;
    logic [EXP_WIDTH-1:0]      exponent_reg;
    pc_t                       pc_reg;
    pc_t                       pc_next;
    logic [EXP_CNT_WIDTH-1:0]  ecnt_reg;
    logic [W-1:0]              acc_reg;
    logic [W-1:0]              base_reg;
    logic [W-1:0]              byte_reg;
    logic                      mul_active_reg;
    logic                      out_valid_reg;
    logic [CIPHER_WIDTH-1:0]   cipher_reg;

    ctrl_t        ctrl;
    logic [63:0]  mod_ext;
    logic [W-1:0] mod_w;
    logic [63:0]  acc_ext;
    logic         in_accept;
    logic         out_free;
    logic         jump;
    logic         mul_start;
    logic         mul_busy;
    logic         mul_done;
    logic [W-1:0] mul_b;
    logic [W-1:0] mul_result;

    assign mod_ext   = 64'(modulus_reg);
    assign mod_w     = mod_ext[W-1:0];
    assign acc_ext   = 64'(acc_reg);
    assign in_stall  = (pc_reg != S_WAIT);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign cipher_word = cipher_reg;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= CFG_DATA_WIDTH'(1);
            exponent_reg <= EXP_WIDTH'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MODULUS:      modulus_reg  <= cfg_data;
                REG_KEY_EXPONENT: exponent_reg <= EXP_WIDTH'(cfg_data);
                default:          ;
            endcase
        end
    end

    rsa_me_ucode_rom u_rom
    (
        .pc   (pc_reg),
        .ctrl (ctrl)
    );

    always_comb
    begin
        unique case (ctrl.cond)
            C_NO_IN:    jump = !in_accept;
            C_MZERO:    jump = (mod_w == '0);
            C_MUL_WAIT: jump = !mul_done;
            C_EBIT0:    jump = !exponent_reg[ecnt_reg];
            C_CNT_NZ:   jump = (ecnt_reg != '0);
            C_OUT_BUSY: jump = !out_free;
            default:    jump = 1'b0;
        endcase
        pc_next = jump ? ctrl.target : pc_t'(pc_reg + pc_t'(1));
    end

    assign mul_start = (ctrl.act == ACT_MUL) && !mul_active_reg;

    always_comb
    begin
        case (ctrl.msel)
            MSEL_BASE: mul_b = byte_reg;
            MSEL_SQR:  mul_b = acc_reg;
            MSEL_MULB: mul_b = base_reg;
            default:   mul_b = acc_reg;
        endcase
    end

    rsa_me_mulmod #(.W(W)) u_mulmod
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (acc_reg),
        .b      (mul_b),
        .m      (mod_w),
        .busy   (mul_busy),
        .done   (mul_done),
        .result (mul_result)
    );

    // sequencer and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg         <= S_WAIT;
            ecnt_reg       <= '0;
            mul_active_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pc_reg <= pc_next;
            if (mul_start)
            begin
                mul_active_reg <= 1'b1;
            end
            else if (mul_done)
            begin
                mul_active_reg <= 1'b0;
            end
            if ((ctrl.act == ACT_LOAD) && in_accept)
            begin
                ecnt_reg <= EXP_CNT_WIDTH'(EXP_WIDTH - 1);
            end
            else if ((ctrl.act == ACT_DEC) && (ecnt_reg != '0))
            begin
                ecnt_reg <= ecnt_reg - EXP_CNT_WIDTH'(1);
            end
            if ((ctrl.act == ACT_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if ((ctrl.act == ACT_LOAD) && in_accept)
        begin
            byte_reg <= W'(message_byte);
            acc_reg  <= W'(mod_w > W'(1));
        end
        if ((ctrl.act == ACT_MUL) && mul_done)
        begin
            if (ctrl.msel == MSEL_BASE)
            begin
                base_reg <= mul_result;
            end
            else
            begin
                acc_reg <= mul_result;
            end
        end
        if ((ctrl.act == ACT_OUT) && out_free)
        begin
            cipher_reg <= acc_ext[CIPHER_WIDTH-1:0];
        end
    end

    // a multiply step never advances before its product is back
    a_mul_step_holds: assert property (@(posedge clk) disable iff (!rst_n)
        ((ctrl.act == ACT_MUL) && !mul_done) |=> (pc_reg == $past(pc_reg)))
        else $error("multiply step left early");

    // the multiplier is only busy inside a multiply step
    a_mul_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        mul_busy |-> ((ctrl.act == ACT_MUL) && mul_active_reg))
        else $error("multiplier busy outside a multiply step");

    // a request restarts the exponent scan from the top bit
    a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> ((ecnt_reg == EXP_CNT_WIDTH'(EXP_WIDTH - 1)) && (pc_reg == S_CHKM)))
        else $error("exponent scan not restarted");

    // the output step leaves a result pending whenever the output slot is free
    a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        ((pc_reg == S_OUT) && out_free) |=> (out_valid_reg && (pc_reg == S_WAIT)))
        else $error("result not posted");

endmodule

// ===== dv/rsa_modexp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_modexp_checker
// Watches the key, request and cipher channels of the modular exponentiation
// block. Keeps its own copy of modulus and key exponent, predicts
// message_byte ^ key_exponent mod modulus for every accepted request, and
// compares each accepted cipher_word in order against the oldest prediction.
// ----------------------------------------------------------------------------
module rsa_modexp_checker
    import rsa_me_pkg::*;
#(
    parameter int MOD_WIDTH = 32
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic [BYTE_WIDTH-1:0]      message_byte,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic [CIPHER_WIDTH-1:0]    cipher_word,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    output int                         mismatch_count,
    output int                         cipher_backlog
);

    logic [CFG_DATA_WIDTH-1:0] modulus_q;
    logic [CFG_DATA_WIDTH-1:0] exponent_q;
    logic [CIPHER_WIDTH-1:0]   pending_ciphers[$];
    logic [CIPHER_WIDTH-1:0]   want;
    int                        errors = 0;

    // square-and-multiply, reduced after every product
    function automatic logic [CIPHER_WIDTH-1:0] mod_pow(
        logic [BYTE_WIDTH-1:0]     m,
        logic [CFG_DATA_WIDTH-1:0] e,
        logic [CFG_DATA_WIDTH-1:0] n
    );
        logic [63:0] wmask;
        logic [63:0] nn;
        logic [63:0] acc;
        logic [63:0] base;
        wmask = (64'd1 << MOD_WIDTH) - 64'd1;
        nn = {32'd0, n} & wmask;
        if (nn == 64'd0)
        begin
            return '0;
        end
        acc  = 64'd1 % nn;
        base = {56'd0, m} % nn;
        for (int i = EXP_WIDTH - 1; i >= 0; i--)
        begin
            acc = (acc * acc) % nn;
            if (e[i])
            begin
                acc = (acc * base) % nn;
            end
        end
        return acc[CIPHER_WIDTH-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_q  <= 32'd1;
            exponent_q <= 32'd1;
            pending_ciphers.delete();
            cipher_backlog <= 0;
            mismatch_count <= errors;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MODULUS:      modulus_q  <= cfg_data;
                    REG_KEY_EXPONENT: exponent_q <= cfg_data;
                    default:          ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (pending_ciphers.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("%0t: unexpected cipher_word %h", $time, cipher_word);
                    end
                end
                else
                begin
                    want = pending_ciphers.pop_front();
                    if (cipher_word !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("%0t: cipher_word expected %h actual %h",
                                     $time, want, cipher_word);
                        end
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                pending_ciphers.push_back(mod_pow(message_byte, exponent_q, modulus_q));
            end
            cipher_backlog <= pending_ciphers.size();
            mismatch_count <= errors;
        end
    end

endmodule

// ===== dv/tb_rsa_modular_exponentiation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rsa_modular_exponentiation
// Drives key writes and plaintext bytes into the RSA modular exponentiation
// block: a directed set of corner keys and bytes, then random keys and bytes
// under several sender-gap and receiver-stall mixes. Checking is done by
// rsa_modexp_checker; this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_rsa_modular_exponentiation;
    import rsa_me_pkg::*;

    localparam int         MOD_WIDTH     = 32;
    localparam longint     LIMIT_NS      = 64'd60_000_000;
    localparam int         DRAIN_CYCLES  = 2400;
    localparam int         KEYS_PER_MIX  = 4;
    localparam int         BYTES_PER_KEY = 17;
    localparam cfg_index_t REG_SPARE_LO  = 8'd2;
    localparam cfg_index_t REG_SPARE_HI  = 8'hFF;

    logic                       clk;
    logic                       rst_n        = 1'b0;
    logic                       in_valid     = 1'b0;
    logic                       in_stall;
    logic [BYTE_WIDTH-1:0]      message_byte = '0;
    logic                       out_valid;
    logic                       out_stall    = 1'b0;
    logic [CIPHER_WIDTH-1:0]    cipher_word;
    logic                       cfg_valid    = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index    = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data     = '0;
    int                         mismatch_count;
    int                         cipher_backlog;
    int                         idle_pct     = 0;
    int                         stall_pct    = 0;

    rsa_modular_exponentiation #(
        .MOD_WIDTH(MOD_WIDTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .message_byte(message_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cipher_word (cipher_word),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    rsa_modexp_checker #(
        .MOD_WIDTH(MOD_WIDTH)
    ) cipher_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .message_byte  (message_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cipher_word   (cipher_word),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatch_count(mismatch_count),
        .cipher_backlog(cipher_backlog)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // leaves cfg_valid high so back-to-back writes need no lowering
    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_WIDTH-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic set_key(logic [CFG_DATA_WIDTH-1:0] n, logic [CFG_DATA_WIDTH-1:0] e);
        write_reg(REG_MODULUS, n);
        write_reg(REG_KEY_EXPONENT, e);
        cfg_valid <= 1'b0;
    endtask

    // the gap comes first, so in_valid stays high across back-to-back requests
    task automatic encrypt_byte(logic [BYTE_WIDTH-1:0] b);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        message_byte <= b;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (cipher_backlog != 0);
    endtask

    initial
    begin
        logic [CFG_DATA_WIDTH-1:0] n_pick;
        logic [CFG_DATA_WIDTH-1:0] e_pick;
        logic [BYTE_WIDTH-1:0]     b_pick;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // modulus of one after reset
        encrypt_byte(8'h00);
        encrypt_byte(8'hFF);
        settle();

        set_key(32'd3233, 32'd17);
        encrypt_byte(8'h00);
        encrypt_byte(8'h01);
        encrypt_byte(8'h41);
        encrypt_byte(8'hFF);
        encrypt_byte(8'hAA);
        encrypt_byte(8'h55);
        settle();

        // zero exponent
        set_key(32'd3233, 32'd0);
        encrypt_byte(8'h00);
        encrypt_byte(8'h07);
        encrypt_byte(8'hFF);
        settle();

        set_key(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        encrypt_byte(8'h00);
        encrypt_byte(8'h02);
        encrypt_byte(8'hFF);
        encrypt_byte(8'h80);
        settle();

        // bytes at, above and just below the modulus
        set_key(32'd200, 32'h8000_0001);
        encrypt_byte(8'd200);
        encrypt_byte(8'hFF);
        encrypt_byte(8'd199);
        settle();

        // zero modulus
        set_key(32'd0, 32'h1234_5678);
        encrypt_byte(8'h05);
        encrypt_byte(8'hFF);
        settle();

        // unmapped indexes are ignored
        write_reg(REG_SPARE_LO, 32'h5A5A_5A5A);
        write_reg(REG_SPARE_HI, 32'hA5A5_A5A5);
        set_key(32'd1, 32'd0);
        encrypt_byte(8'h09);
        settle();

        for (int mix = 0; mix < 4; mix++)
        begin
            case (mix)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 82; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 82; end
                default: begin idle_pct = 23; stall_pct = 23; end
            endcase
            for (int k = 0; k < KEYS_PER_MIX; k++)
            begin
                case ($urandom_range(3))
                    0:       n_pick = $urandom | 32'h8000_0000;
                    1:       n_pick = $urandom_range(300, 2);
                    2:       n_pick = $urandom;
                    default: n_pick = $urandom_range(1) ? 32'hFFFF_FFFF : 32'd1;
                endcase
                case ($urandom_range(3))
                    0:       e_pick = $urandom;
                    1:       e_pick = $urandom_range(20, 0);
                    2:       e_pick = 32'd65537;
                    default: e_pick = $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
                endcase
                set_key(n_pick, e_pick);
                repeat (BYTES_PER_KEY)
                begin
                    if ($urandom_range(3) == 0)
                    begin
                        b_pick = $urandom_range(1) ? 8'hFF : 8'h00;
                    end
                    else
                    begin
                        b_pick = $urandom_range(255);
                    end
                    encrypt_byte(b_pick);
                end
                settle();
            end
        end

        idle_pct  = 0;
        stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("** rsa_modular_exponentiation: PASSED **");
        end
        else
        begin
            $display("** rsa_modular_exponentiation: FAILED **");
        end
        $finish;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("timeout");
        $display("** rsa_modular_exponentiation: FAILED **");
        $finish;
    end

endmodule

// ===== rsa_modular_exponentiation.f =====
rtl/rsa_me_pkg.sv
rtl/rsa_me_ucode_rom.sv
rtl/rsa_me_mulmod.sv
rtl/rsa_modular_exponentiation.sv
dv/rsa_modexp_checker.sv
dv/tb_rsa_modular_exponentiation.sv
